[design/sat_pkg.sv]
`timescale 1ns / 1ps
// Package for the section address translation block: request codes,
// table entry, write and search token types. No dependencies.
package sat_pkg;

  // default table depth
  localparam int NUM_SECTIONS_DEF = 16;

  // widths fixed by the item fields
  localparam int IDX_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 4;

  // request types
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_RVA    = 2'd1;
  localparam logic [1:0] REQ_OFFSET = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 4'd1;

  // one section descriptor
  typedef struct packed {
    logic [31:0] vaddr;
    logic [31:0] vsize;
    logic [31:0] rawptr;
    logic [31:0] rawsize;
  } entry_t;

  // table write broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    entry_t           entry;
  } wr_t;

  // search token walking down the chain of cells
  typedef struct packed {
    logic             valid;
    logic             by_offset;
    logic [63:0]      query;
    logic             found;
    logic [IDX_W-1:0] index;
    logic [31:0]      delta;
    entry_t           hit;
  } token_t;

endpackage

[design/sat_req_if.sv]
`timescale 1ns / 1ps
// Request channel interface for the section address translation block.
// Depends on nothing.
interface sat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  entry_index;
  logic [31:0] entry_virtual_address;
  logic [31:0] entry_virtual_size;
  logic [31:0] entry_raw_pointer;
  logic [31:0] entry_raw_size;
  logic [31:0] query_rva;
  logic [63:0] query_file_offset;

  modport source (
    output valid, req_type, entry_index, entry_virtual_address, entry_virtual_size,
           entry_raw_pointer, entry_raw_size, query_rva, query_file_offset,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_virtual_address, entry_virtual_size,
           entry_raw_pointer, entry_raw_size, query_rva, query_file_offset,
    output ready
  );
endinterface

[design/sat_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel interface for the section address translation block.
// Depends on nothing.
interface sat_rsp_if;
  logic        valid;
  logic        ready;
  logic        section_found;
  logic [3:0]  match_index;
  logic        rva_present;
  logic [31:0] result_rva;
  logic        va_present;
  logic [63:0] result_va;
  logic        file_present;
  logic [63:0] result_file_offset;
  logic        fully_valid;

  modport source (
    output valid, section_found, match_index, rva_present, result_rva, va_present,
           result_va, file_present, result_file_offset, fully_valid,
    input  ready
  );
  modport sink (
    input  valid, section_found, match_index, rva_present, result_rva, va_present,
           result_va, file_present, result_file_offset, fully_valid,
    output ready
  );
endinterface

[design/sat_cfg_if.sv]
`timescale 1ns / 1ps
// Configuration write channel interface for the section address translation block.
// Depends on nothing.
interface sat_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/sat_cell.sv]
`timescale 1ns / 1ps
// One table cell: holds a section descriptor and checks the passing token.
// Depends on sat_pkg.
module sat_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sat_pkg::wr_t                 wr,
  input  logic [sat_pkg::COUNT_W-1:0]  section_count,
  input  sat_pkg::token_t              tok_in,
  output sat_pkg::token_t              tok_out
);

  localparam logic [sat_pkg::IDX_W-1:0] IDX_BITS = IDX[sat_pkg::IDX_W-1:0];

  sat_pkg::entry_t ent;
  logic            ent_valid;
  sat_pkg::entry_t cur;
  logic [31:0]     span;
  logic [31:0]     vend;
  logic [63:0]     ptr_ext;
  logic [63:0]     off_end;
  logic            rva_hit;
  logic            off_hit;
  logic            in_range;
  logic            take;
  sat_pkg::token_t tok_next;

  // an entry never written reads as all zero
  assign cur = ent_valid ? ent : '0;

  // relative address range check, end wraps at 32 bits
  assign span    = (cur.vsize != 32'd0) ? cur.vsize : cur.rawsize;
  assign vend    = cur.vaddr + span;
  assign rva_hit = (span != 32'd0) && (tok_in.query[31:0] >= cur.vaddr) &&
                   (tok_in.query[31:0] < vend);

  // file offset range check at full width
  assign ptr_ext = {32'd0, cur.rawptr};
  assign off_end = ptr_ext + {32'd0, cur.rawsize};
  assign off_hit = (cur.rawptr != 32'd0) && (cur.rawsize != 32'd0) &&
                   (tok_in.query >= ptr_ext) && (tok_in.query < off_end);

  assign in_range = IDX < int'(section_count);
  assign take     = tok_in.valid && !tok_in.found && in_range &&
                    (tok_in.by_offset ? off_hit : rva_hit);

  // descriptor storage
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (wr.en && (IDX < (1 << sat_pkg::IDX_W)) && (wr.index == IDX_BITS)) begin
      ent_valid <= 1'b1;
      ent       <= wr.entry;
    end
  end

  // token as handed on, marked on the first match
  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.index = IDX_BITS;
      tok_next.hit   = cur;
      tok_next.delta = tok_in.by_offset ? (tok_in.query[31:0] - cur.rawptr)
                                        : (tok_in.query[31:0] - cur.vaddr);
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

[design/sat_result.sv]
`timescale 1ns / 1ps
// Result stage: parks the finished token and forms the translated fields
// into the output register. Depends on sat_pkg and sat_rsp_if.
module sat_result (
  input  logic            clk,
  input  logic            rst,
  input  sat_pkg::token_t tok_in,
  input  logic [63:0]     base_addr,
  output logic            retire,
  sat_rsp_if.source       rsp
);

  sat_pkg::token_t pend;
  logic            pend_valid;
  logic            out_valid;
  logic            take;

  logic        found;
  logic [3:0]  index;
  logic        rva_p;
  logic [31:0] rva;
  logic        va_p;
  logic [63:0] va;
  logic        file_p;
  logic [63:0] foff;
  logic        fv;

  assign take   = out_valid && rsp.ready;
  assign retire = pend_valid && (!out_valid || take);

  // field formation from the parked token
  always_comb begin
    found  = pend.found;
    index  = pend.index;
    rva_p  = 1'b0;
    rva    = 32'd0;
    va_p   = 1'b0;
    va     = 64'd0;
    file_p = 1'b0;
    foff   = 64'd0;
    fv     = 1'b0;
    if (pend.by_offset) begin
      file_p = 1'b1;
      foff   = pend.query;
      if (pend.found) begin
        rva_p = 1'b1;
        rva   = pend.hit.vaddr + pend.delta;
        va_p  = 1'b1;
        va    = base_addr + {32'd0, rva};
        fv    = 1'b1;
      end
    end else begin
      rva_p = 1'b1;
      rva   = pend.query[31:0];
      va_p  = 1'b1;
      va    = base_addr + {32'd0, rva};
      if (pend.found && (pend.hit.rawptr != 32'd0) && (pend.delta < pend.hit.rawsize)) begin
        file_p = 1'b1;
        foff   = {32'd0, pend.hit.rawptr} + {32'd0, pend.delta};
        fv     = 1'b1;
      end
    end
  end

  // parking register for the token leaving the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (tok_in.valid) begin
      pend_valid <= 1'b1;
      pend       <= tok_in;
    end else if (retire) begin
      pend_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire) begin
      out_valid              <= 1'b1;
      rsp.section_found      <= found;
      rsp.match_index        <= index;
      rsp.rva_present        <= rva_p;
      rsp.result_rva         <= rva;
      rsp.va_present         <= va_p;
      rsp.result_va          <= va;
      rsp.file_present       <= file_p;
      rsp.result_file_offset <= foff;
      rsp.fully_valid        <= fv;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid = out_valid;

endmodule

[design/section_address_translation.sv]
`timescale 1ns / 1ps
// Section address translation: a table of NUM_SECTIONS section descriptors held in a
// chain of cells, one descriptor per cell. A write request fills one cell and is taken
// with no result. A query sends a token down the chain, one cell per cycle, and the
// first cell that matches within section_count marks it; the token then parks in a
// result stage that forms the addresses into the output register. The token
// is registered in every cell, then in the parking stage and in the output register.
// The next request is taken once the previous result has reached the output register,
// so a result waiting there does not hold up the next request, but a stalled output
// register holds the following query in the parking stage. Config writes are always
// taken and must only be made while no query is in flight.
// Depends on sat_pkg, sat_req_if, sat_rsp_if, sat_cfg_if, sat_cell and sat_result.
module section_address_translation #(
  parameter int NUM_SECTIONS = sat_pkg::NUM_SECTIONS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sat_req_if.sink   req,
  sat_rsp_if.source rsp,
  sat_cfg_if.sink   cfg
);

  logic [63:0]                    base_addr;
  logic [sat_pkg::COUNT_W-1:0]    section_count;
  logic                           busy;
  logic                           accept;
  logic                           is_query;
  logic                           retire;
  sat_pkg::wr_t                   wr;
  sat_pkg::token_t                tok [0:NUM_SECTIONS];

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr     <= 64'd0;
      section_count <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        sat_pkg::CFG_BASE_ADDR:     base_addr     <= cfg.data;
        sat_pkg::CFG_SECTION_COUNT: section_count <= cfg.data[sat_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request intake, one query in flight at a time
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;
  assign is_query  = (req.req_type == sat_pkg::REQ_RVA) ||
                     (req.req_type == sat_pkg::REQ_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && is_query) begin
      busy <= 1'b1;
    end else if (retire) begin
      busy <= 1'b0;
    end
  end

  // table write broadcast
  always_comb begin
    wr               = '0;
    wr.en            = accept && (req.req_type == sat_pkg::REQ_WRITE);
    wr.index         = req.entry_index;
    wr.entry.vaddr   = req.entry_virtual_address;
    wr.entry.vsize   = req.entry_virtual_size;
    wr.entry.rawptr  = req.entry_raw_pointer;
    wr.entry.rawsize = req.entry_raw_size;
  end

  // token injected at the head of the chain
  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = accept && is_query;
    tok[0].by_offset = (req.req_type == sat_pkg::REQ_OFFSET);
    tok[0].query     = tok[0].by_offset ? req.query_file_offset : {32'd0, req.query_rva};
  end

  // chain of table cells
  for (genvar i = 0; i < NUM_SECTIONS; i++) begin : g_cell
    sat_cell #(
      .IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .wr            (wr),
      .section_count (section_count),
      .tok_in        (tok[i]),
      .tok_out       (tok[i+1])
    );
  end

  // result formation and output register
  sat_result u_result (
    .clk       (clk),
    .rst       (rst),
    .tok_in    (tok[NUM_SECTIONS]),
    .base_addr (base_addr),
    .retire    (retire),
    .rsp       (rsp)
  );

endmodule
